### rtl/core/mkh_pkg.sv
// Shared constants, types and arithmetic helpers for the key hasher.
package mkh_pkg;

  // Hash constants
  localparam logic [31:0] MixMul    = 32'h5bd1e995;
  localparam int unsigned MixShift  = 24;
  localparam int unsigned FinShiftA = 13;
  localparam int unsigned FinShiftB = 15;

  // Queue between the front and the back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Stream widths
  localparam int unsigned WordW     = 32;
  localparam int unsigned CountW    = 3;
  localparam int unsigned InDataW   = 40;  // word + count, padded to bytes
  localparam int unsigned OutDataW  = 32;

  // What the back end does with a queued word
  typedef enum logic [1:0] {
    KIND_BODY,       // full block, key continues
    KIND_BODY_LAST,  // full block, then finalise
    KIND_TAIL,       // one to three tail bytes, then finalise
    KIND_EMPTY       // nothing to mix, only finalise
  } mkh_kind_e;

  typedef struct packed {
    mkh_kind_e         kind;
    logic [WordW-1:0]  k;
  } mkh_entry_t;

  typedef enum logic [1:0] {
    ST_MIX,
    ST_FIN_MUL,
    ST_FIN_OUT
  } mkh_state_e;

  // Low 32 bits of a 32 x 32 product
  function automatic logic [WordW-1:0] mul32(input logic [WordW-1:0] a,
                                             input logic [WordW-1:0] b);
    logic [2*WordW-1:0] prod;
    prod = {{WordW{1'b0}}, a} * {{WordW{1'b0}}, b};
    return prod[WordW-1:0];
  endfunction

  // Keeps the valid tail bytes of a short last word
  function automatic logic [WordW-1:0] tail_mask(input logic [CountW-1:0] cnt);
    logic [WordW-1:0] m;
    case (cnt)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/mkh_front.sv
// Front end: accepts key words, classifies them and premixes the block value k.
module mkh_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mkh_pkg::WordW-1:0]     word_i,
  input  logic [mkh_pkg::CountW-1:0]    count_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mkh_pkg::mkh_entry_t           out_entry_o
);

  logic                       valid_a_q, valid_b_q;
  mkh_pkg::mkh_kind_e         kind_a_q;
  logic [mkh_pkg::WordW-1:0]  k_a_q;
  mkh_pkg::mkh_entry_t        entry_b_q;

  logic                       adv_a, adv_b;
  mkh_pkg::mkh_kind_e         kind_in;
  logic [mkh_pkg::WordW-1:0]  k_a_d, k_sh, k_b_d;

  // Stage advance: a stage moves when the one after it has room
  assign adv_b      = !valid_b_q || out_ready_i;
  assign adv_a      = !valid_a_q || adv_b;
  assign in_ready_o = adv_a;

  // Classify the incoming word
  always_comb begin
    if (!last_i) begin
      kind_in = mkh_pkg::KIND_BODY;
    end else if (count_i inside {[3'd4:3'd7]}) begin
      kind_in = mkh_pkg::KIND_BODY_LAST;
    end else if (count_i == '0) begin
      kind_in = mkh_pkg::KIND_EMPTY;
    end else begin
      kind_in = mkh_pkg::KIND_TAIL;
    end
  end

  // First multiply for blocks, byte mask for tails
  always_comb begin
    case (kind_in)
      mkh_pkg::KIND_BODY,
      mkh_pkg::KIND_BODY_LAST: k_a_d = mkh_pkg::mul32(word_i, mkh_pkg::MixMul);
      mkh_pkg::KIND_TAIL:      k_a_d = word_i & mkh_pkg::tail_mask(count_i);
      default:                 k_a_d = '0;
    endcase
  end

  // Shift-xor and second multiply for blocks
  assign k_sh = k_a_q ^ (k_a_q >> mkh_pkg::MixShift);
  always_comb begin
    case (kind_a_q)
      mkh_pkg::KIND_BODY,
      mkh_pkg::KIND_BODY_LAST: k_b_d = mkh_pkg::mul32(k_sh, mkh_pkg::MixMul);
      default:                 k_b_d = k_a_q;
    endcase
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (adv_a) begin
        valid_a_q <= in_valid_i;
      end
      if (adv_b) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv_a && in_valid_i) begin
      kind_a_q <= kind_in;
      k_a_q    <= k_a_d;
    end
    if (adv_b && valid_a_q) begin
      entry_b_q.kind <= kind_a_q;
      entry_b_q.k    <= k_b_d;
    end
  end

  assign out_valid_o = valid_b_q;
  assign out_entry_o = entry_b_q;

  // A stalled second stage keeps its word
  a_hold_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_b_q && !out_ready_i) |=> (valid_b_q && $stable(entry_b_q)))
    else $error("front stage B lost its word under stall");

  // A stalled first stage keeps its word
  a_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_a_q && valid_b_q && !out_ready_i) |=> (valid_a_q && $stable(k_a_q)))
    else $error("front stage A lost its word under stall");

endmodule

### rtl/core/mkh_fifo.sv
// Short queue of classified words between the front and the back.
module mkh_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  mkh_pkg::mkh_entry_t  push_entry_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output mkh_pkg::mkh_entry_t  pop_entry_o
);

  mkh_pkg::mkh_entry_t                entries_q [mkh_pkg::FifoDepth];
  logic [mkh_pkg::FifoPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [mkh_pkg::FifoCntW-1:0]       count_q;
  logic                               push, pop;

  assign push_ready_o = (count_q != mkh_pkg::FifoCntW'(mkh_pkg::FifoDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = entries_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mkh_pkg::FifoCntW'(mkh_pkg::FifoDepth))
    else $error("queue fill level beyond depth");

  // Pointer distance always matches the fill level
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[mkh_pkg::FifoPtrW-1:0])
    else $error("queue pointers disagree with fill level");

endmodule

### rtl/core/mkh_back.sv
// Back end: running hash recurrence, tail mixing, finaliser and output register.
module mkh_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mkh_pkg::mkh_entry_t           in_entry_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mkh_pkg::WordW-1:0]     out_hash_o
);

  mkh_pkg::mkh_state_e        state_q, state_d;
  logic [mkh_pkg::WordW-1:0]  h_q, h_d;
  logic                       out_valid_q, out_valid_d;
  logic [mkh_pkg::WordW-1:0]  out_hash_q, out_hash_d;
  logic                       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state, hash update and output load
  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_hash_d  = out_hash_q;
    in_ready_o  = 1'b0;
    case (state_q)
      mkh_pkg::ST_MIX: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_entry_i.kind)
            mkh_pkg::KIND_BODY: begin
              h_d = mkh_pkg::mul32(h_q, mkh_pkg::MixMul) ^ in_entry_i.k;
            end
            mkh_pkg::KIND_BODY_LAST: begin
              h_d     = mkh_pkg::mul32(h_q, mkh_pkg::MixMul) ^ in_entry_i.k;
              state_d = mkh_pkg::ST_FIN_MUL;
            end
            mkh_pkg::KIND_TAIL: begin
              h_d     = mkh_pkg::mul32(h_q ^ in_entry_i.k, mkh_pkg::MixMul);
              state_d = mkh_pkg::ST_FIN_MUL;
            end
            default: begin
              state_d = mkh_pkg::ST_FIN_MUL;
            end
          endcase
        end
      end
      mkh_pkg::ST_FIN_MUL: begin
        h_d     = mkh_pkg::mul32(h_q ^ (h_q >> mkh_pkg::FinShiftA), mkh_pkg::MixMul);
        state_d = mkh_pkg::ST_FIN_OUT;
      end
      mkh_pkg::ST_FIN_OUT: begin
        // Last shift-xor goes straight into the output register
        if (out_free) begin
          out_valid_d = 1'b1;
          out_hash_d  = h_q ^ (h_q >> mkh_pkg::FinShiftB);
          h_d         = '0;
          state_d     = mkh_pkg::ST_MIX;
        end
      end
      default: begin
        state_d = mkh_pkg::ST_MIX;
      end
    endcase
  end

  // Control and running hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mkh_pkg::ST_MIX;
      h_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    out_hash_q <= out_hash_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_hash_o  = out_hash_q;

  // Emitting a hash clears the running hash for the next key
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mkh_pkg::ST_FIN_OUT && out_free) |=> (h_q == '0))
    else $error("running hash not cleared after emit");

  // A new result word only comes from the output state
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && !out_ready_i))
      |-> $past(state_q == mkh_pkg::ST_FIN_OUT))
    else $error("result word appeared outside the output state");

endmodule

### rtl/core/murmur2_key_hash.sv
// Top level: streaming 32-bit MurmurHash2 over little-endian key words.
// A last word passes the premix stages, the queue, the mix, the finalise multiply and
//   the output register before its hash is shown.
// Throughput: one non-last word per cycle while nothing stalls; each key end holds the
//   back end through the finalise multiply and output steps that follow the mix.
// Reset clears the running hash, the premix stages, the queue and the output valid.
module murmur2_key_hash (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mkh_pkg::InDataW-1:0]     s_axis_tdata,  // data_word[31:0], byte_count[34:32]
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mkh_pkg::OutDataW-1:0]    m_axis_tdata   // hash_value[31:0]
);

  logic                 q_push_valid, q_push_ready;
  mkh_pkg::mkh_entry_t  q_push_entry;
  logic                 q_pop_valid, q_pop_ready;
  mkh_pkg::mkh_entry_t  q_pop_entry;
  logic [mkh_pkg::InDataW-1:mkh_pkg::WordW+mkh_pkg::CountW] unused_pad;

  assign unused_pad = s_axis_tdata[mkh_pkg::InDataW-1:mkh_pkg::WordW+mkh_pkg::CountW];

  mkh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .word_i      (s_axis_tdata[mkh_pkg::WordW-1:0]),
    .count_i     (s_axis_tdata[mkh_pkg::WordW+mkh_pkg::CountW-1:mkh_pkg::WordW]),
    .last_i      (s_axis_tlast),
    .out_valid_o (q_push_valid),
    .out_ready_i (q_push_ready),
    .out_entry_o (q_push_entry)
  );

  mkh_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_entry_i (q_push_entry),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_entry_o  (q_pop_entry)
  );

  mkh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_pop_valid),
    .in_ready_o  (q_pop_ready),
    .in_entry_i  (q_pop_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hash_o  (m_axis_tdata)
  );

endmodule
